// ===== hw/rtl/bmpd_pkg.sv =====
// bmpd_pkg: shared types, constants and the fade table of the bar meter
// used by bmpd_front, bmpd_queue, bmpd_back and bar_meter_peak_decay
// depends on nothing
`default_nettype none

package bmpd_pkg;

    // default sizes of the meter
    localparam int COLUMNS_DEF    = 16;
    localparam int ROWS_DEF       = 8;
    localparam int FADE_STEPS_DEF = 20;

    // field widths
    localparam int COL_W    = 4;
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 5;
    localparam int LIT_W    = 4;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT = 1'd1;

    // reset value of the intensity register
    localparam logic [SAMPLE_W-1:0] INTENSITY_RST = 16'hFFFF;

    // opcode of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    // decay curve in Q1.16, one entry per fade step before the final, dark one
    localparam int CURVE_LEN = 19;
    localparam logic [16:0] CURVE_Q16 [CURVE_LEN] = '{
        17'd65536, 17'd63170, 17'd60693, 17'd58091, 17'd55365, 17'd52521,
        17'd49558, 17'd46472, 17'd43267, 17'd39938, 17'd36484, 17'd32919,
        17'd29223, 17'd25415, 17'd21476, 17'd17426, 17'd13251, 17'd8952,
        17'd4535
    };

    typedef enum logic {
        CMD_LOAD,
        CMD_TICK
    } cmd_kind_t;

    // classified item travelling from front to back
    typedef struct packed {
        cmd_kind_t             kind;
        logic                  hit;     // load column is a real column
        logic [COL_W-1:0]      column;
        logic [SAMPLE_W-1:0]   sample;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_CALC,
        BK_EMIT
    } back_state_t;

    // factor of a fade step; final step and beyond are dark
    function automatic logic [16:0] fade_factor(input logic [STEP_W-1:0] step,
                                                input int fade_steps);
        logic [16:0] f;
        if (int'(step) >= fade_steps - 1)
            f = 17'd0;
        else if (int'(step) >= CURVE_LEN)
            f = CURVE_Q16[CURVE_LEN-1];
        else
            f = CURVE_Q16[step];
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmpd_front.sv =====
// bmpd_front: input handshake and item classification
// holds one classified item until the queue takes it; uses bmpd_pkg
`default_nettype none

module bmpd_front #(
    parameter int COLUMNS = bmpd_pkg::COLUMNS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          opcode,
    input  wire [bmpd_pkg::COL_W-1:0]    column,
    input  wire [bmpd_pkg::SAMPLE_W-1:0] sample,
    output logic                         push_valid,
    input  wire                          push_ready,
    output bmpd_pkg::cmd_t               push_cmd
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    bmpd_pkg::cmd_t cmd_reg;
    bmpd_pkg::cmd_t cmd_next;
    logic           accept;

    // take a new item when the holding stage is empty or drains now
    assign in_ready   = !hold_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    // classify the item
    always_comb
    begin
        cmd_next.kind   = (opcode == bmpd_pkg::OP_TICK) ? bmpd_pkg::CMD_TICK
                                                        : bmpd_pkg::CMD_LOAD;
        cmd_next.hit    = (int'(column) < COLUMNS);
        cmd_next.column = column;
        cmd_next.sample = sample;
        if (accept)
            hold_valid_next = 1'b1;
        else if (push_ready)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    // holding stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    // holding stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bmpd_queue.sv =====
// bmpd_queue: short fifo of classified items between front and back
// uses bmpd_pkg for the item type and depth
`default_nettype none

module bmpd_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push_valid,
    output logic           push_ready,
    input  bmpd_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  wire            pop_ready,
    output bmpd_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (bmpd_pkg::Q_DEPTH > 1) ? $clog2(bmpd_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(bmpd_pkg::Q_DEPTH + 1);

    bmpd_pkg::cmd_t   entry_reg [bmpd_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(bmpd_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bmpd_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bmpd_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bmpd_back.sv =====
// bmpd_back: executes loads and ticks, holds column state and the result register
// scan pass finds the dark verdict, update pass decays one column at a time; uses bmpd_pkg
`default_nettype none

module bmpd_back #(
    parameter int COLUMNS    = bmpd_pkg::COLUMNS_DEF,
    parameter int ROWS       = bmpd_pkg::ROWS_DEF,
    parameter int FADE_STEPS = bmpd_pkg::FADE_STEPS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write,
    input  wire [bmpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bmpd_pkg::SAMPLE_W-1:0]  cfg_data,
    input  wire                           pop_valid,
    output logic                          pop_ready,
    input  bmpd_pkg::cmd_t                pop_cmd,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [bmpd_pkg::COL_W-1:0]    out_column,
    output logic [bmpd_pkg::SAMPLE_W-1:0] level,
    output logic [bmpd_pkg::LIT_W-1:0]    lit_rows,
    output logic [bmpd_pkg::SAMPLE_W-1:0] brightness,
    output logic                          last,
    output logic                          all_dark
);

    localparam int SW      = bmpd_pkg::SAMPLE_W;
    localparam int CNT_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_CNT_W = $clog2(ROWS + 1);
    localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(COLUMNS - 1);
    localparam logic [bmpd_pkg::STEP_W-1:0] LAST_STEP = bmpd_pkg::STEP_W'(FADE_STEPS - 1);
    localparam logic [SW-1:0] ROW_STEP = SW'(32'hFFFF / ROWS);

    bmpd_pkg::back_state_t state_reg;
    bmpd_pkg::back_state_t state_next;

    // configuration
    logic [SW-1:0] intensity_reg;
    logic [SW-1:0] skip_reg;

    // column state
    logic [SW-1:0]              level_reg [COLUMNS];
    logic [bmpd_pkg::STEP_W-1:0] step_reg [COLUMNS];
    logic [SW-1:0]              pend_reg  [COLUMNS];

    logic [SW-1:0]    prescale_reg;
    logic [SW-1:0]    prescale_next;
    logic             pflag_reg;
    logic             pflag_next;
    logic             running_reg;
    logic             running_next;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic             dark_reg;
    logic             dark_next;
    logic [SW-1:0]    lv_reg;
    logic [SW-1:0]    lv_next;

    // result register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [bmpd_pkg::COL_W-1:0]  out_column_reg;
    logic [SW-1:0]               level_out_reg;
    logic [bmpd_pkg::LIT_W-1:0]  lit_reg;
    logic [SW-1:0]               bright_reg;
    logic                        last_reg;
    logic                        all_dark_reg;

    logic                        take;
    logic [SW-1:0]               base;
    logic [bmpd_pkg::STEP_W-1:0] stp;
    logic [bmpd_pkg::STEP_W-1:0] stp_adv;
    logic [SW+16:0]              decay_prod;
    logic [2*SW-1:0]             bright_prod;
    logic [ROW_CNT_W-1:0]        lit_cnt;
    logic                        pend_we;
    logic                        col_we;
    logic                        out_load;

    // pending sample overrides the held level when it is higher
    assign take    = pflag_reg && (pend_reg[col_reg] > level_reg[col_reg]);
    assign base    = take ? pend_reg[col_reg] : level_reg[col_reg];
    assign stp     = take ? '0 : step_reg[col_reg];
    assign stp_adv = (stp < LAST_STEP) ? stp + 1'b1 : stp;
    assign decay_prod = base * bmpd_pkg::fade_factor(stp, FADE_STEPS);

    // brightness and lit rows from the registered decayed level
    assign bright_prod = lv_reg * intensity_reg;

    always_comb
    begin
        lit_cnt = '0;
        for (int k = 0; k < ROWS; k++)
        begin
            if (32'(lv_reg) > 32'(ROW_STEP) * 32'(k))
                lit_cnt = lit_cnt + 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        prescale_next = prescale_reg;
        pflag_next    = pflag_reg;
        running_next  = running_reg;
        col_next      = col_reg;
        dark_next     = dark_reg;
        lv_next       = lv_reg;
        pop_ready     = 1'b0;
        pend_we       = 1'b0;
        col_we        = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            bmpd_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    case (pop_cmd.kind)
                        bmpd_pkg::CMD_LOAD:
                        begin
                            pend_we      = pop_cmd.hit;
                            pflag_next   = 1'b1;
                            running_next = 1'b1;
                        end
                        bmpd_pkg::CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                if (prescale_reg < skip_reg)
                                    prescale_next = prescale_reg + 1'b1;
                                else
                                begin
                                    prescale_next = '0;
                                    col_next      = '0;
                                    dark_next     = 1'b1;
                                    state_next    = bmpd_pkg::BK_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bmpd_pkg::BK_SCAN:
            begin
                dark_next = dark_reg && !take && (step_reg[col_reg] >= LAST_STEP);
                if (col_reg == LAST_COL)
                begin
                    col_next   = '0;
                    state_next = bmpd_pkg::BK_CALC;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            bmpd_pkg::BK_CALC:
            begin
                col_we     = 1'b1;
                lv_next    = decay_prod[SW+15:16];
                state_next = bmpd_pkg::BK_EMIT;
            end
            bmpd_pkg::BK_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (col_reg == LAST_COL)
                    begin
                        pflag_next = 1'b0;
                        if (dark_reg)
                            running_next = 1'b0;
                        state_next = bmpd_pkg::BK_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = bmpd_pkg::BK_CALC;
                    end
                end
            end
            default:
                state_next = bmpd_pkg::BK_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmpd_pkg::BK_IDLE;
            intensity_reg <= bmpd_pkg::INTENSITY_RST;
            skip_reg      <= '0;
            prescale_reg  <= '0;
            pflag_reg     <= 1'b0;
            running_reg   <= 1'b0;
            col_reg       <= '0;
            dark_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prescale_reg  <= prescale_next;
            pflag_reg     <= pflag_next;
            running_reg   <= running_next;
            col_reg       <= col_next;
            dark_reg      <= dark_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == bmpd_pkg::REG_INTENSITY))
                intensity_reg <= cfg_data;
            if (cfg_write && (cfg_index == bmpd_pkg::REG_SKIP_COUNT))
                skip_reg <= cfg_data;
        end
    end

    // per-column state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                level_reg[i] <= '0;
                step_reg[i]  <= '0;
                pend_reg[i]  <= '0;
            end
        end
        else
        begin
            if (pend_we)
                pend_reg[pop_cmd.column[CNT_W-1:0]] <= pop_cmd.sample;
            if (col_we)
            begin
                level_reg[col_reg] <= decay_prod[SW+15:16];
                step_reg[col_reg]  <= stp_adv;
            end
        end
    end

    // decayed level and result payload
    always_ff @(posedge clk)
    begin
        lv_reg <= lv_next;
        if (out_load)
        begin
            out_column_reg <= bmpd_pkg::COL_W'(col_reg);
            level_out_reg  <= lv_reg;
            lit_reg        <= bmpd_pkg::LIT_W'(lit_cnt);
            bright_reg     <= bright_prod[2*SW-1:SW];
            last_reg       <= (col_reg == LAST_COL);
            all_dark_reg   <= dark_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_column = out_column_reg;
    assign level      = level_out_reg;
    assign lit_rows   = lit_reg;
    assign brightness = bright_reg;
    assign last       = last_reg;
    assign all_dark   = all_dark_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bar_meter_peak_decay.sv =====
// bar meter with peak hold and decay: load items queue a sample, updating tick items emit one item per column
// an accepted item passes the front holding stage and the queue before the back end takes it
// an updating tick scans all columns, then per column result does the decay multiply in the calc state
// and the brightness multiply as it emits the result, waiting while the output register is full
// a 2-entry queue and the front holding stage let the input keep accepting while the back end works, until full
// reset: levels, fade steps and pending samples clear to zero, intensity to full, meter stopped
`default_nettype none

module bar_meter_peak_decay #(
    parameter int COLUMNS    = bmpd_pkg::COLUMNS_DEF,
    parameter int ROWS       = bmpd_pkg::ROWS_DEF,
    parameter int FADE_STEPS = bmpd_pkg::FADE_STEPS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write,
    input  wire [bmpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bmpd_pkg::SAMPLE_W-1:0]  cfg_data,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           opcode,
    input  wire [bmpd_pkg::COL_W-1:0]     column,
    input  wire [bmpd_pkg::SAMPLE_W-1:0]  sample,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [bmpd_pkg::COL_W-1:0]    out_column,
    output logic [bmpd_pkg::SAMPLE_W-1:0] level,
    output logic [bmpd_pkg::LIT_W-1:0]    lit_rows,
    output logic [bmpd_pkg::SAMPLE_W-1:0] brightness,
    output logic                          last,
    output logic                          all_dark
);

    logic           push_valid;
    logic           push_ready;
    bmpd_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    bmpd_pkg::cmd_t pop_cmd;

    // accept and classify
    bmpd_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .column     (column),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    bmpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // execute and emit
    bmpd_back #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .FADE_STEPS (FADE_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_column (out_column),
        .level      (level),
        .lit_rows   (lit_rows),
        .brightness (brightness),
        .last       (last),
        .all_dark   (all_dark)
    );

    // an accepted item always lands in the front holding stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> push_valid)
        else $error("accepted item not held by front");

    // a dark column lights nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (level == '0) |-> (lit_rows == '0) && (brightness == '0))
        else $error("zero level with lit rows or brightness");

    // the final item of a tick describes the final column
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_column == bmpd_pkg::COL_W'(COLUMNS - 1))
        else $error("last flag on wrong column");

endmodule

`default_nettype wire

// ===== sim/bmpd_tb_pkg.sv =====
// bmpd_tb_pkg: meter_book class that mirrors the bar meter state and checks its column items
// works out the column items of every accepted item and compares arriving items in order
// depends on bmpd_pkg
`timescale 1ns / 100ps

package bmpd_tb_pkg;

    localparam int NCOL = bmpd_pkg::COLUMNS_DEF;
    localparam int NROW = bmpd_pkg::ROWS_DEF;
    localparam int NFADE = bmpd_pkg::FADE_STEPS_DEF;
    localparam logic [bmpd_pkg::SAMPLE_W-1:0] ROW_SPAN = bmpd_pkg::SAMPLE_W'(16'hFFFF / NROW);
    localparam int REPORT_LIMIT = 10;

    // one column item of an updating tick
    typedef struct packed {
        logic [bmpd_pkg::COL_W-1:0]    col;
        logic [bmpd_pkg::SAMPLE_W-1:0] lvl;
        logic [bmpd_pkg::LIT_W-1:0]    lit;
        logic [bmpd_pkg::SAMPLE_W-1:0] bright;
        logic                          fin;
        logic                          dark;
    } column_report_t;

    class meter_book;
        // mirrored registers
        logic [bmpd_pkg::SAMPLE_W-1:0] intensity;
        logic [bmpd_pkg::SAMPLE_W-1:0] skip_count;
        // mirrored meter state
        logic [bmpd_pkg::SAMPLE_W-1:0] prescale;
        logic [bmpd_pkg::SAMPLE_W-1:0] held [NCOL];
        logic [bmpd_pkg::STEP_W-1:0]   fade_stage [NCOL];
        logic [bmpd_pkg::SAMPLE_W-1:0] pend_val [NCOL];
        logic                          pend_flag;
        logic                          running;
        // column items still to arrive, oldest first
        column_report_t                awaited [$];
        int                            errors;

        function new();
            intensity = bmpd_pkg::INTENSITY_RST;
            skip_count = '0;
            prescale = '0;
            foreach (held[i])
            begin
                held[i] = '0;
                fade_stage[i] = '0;
                pend_val[i] = '0;
            end
            pend_flag = 1'b0;
            running = 1'b0;
            errors = 0;
        endfunction

        function void set_regs(logic [bmpd_pkg::SAMPLE_W-1:0] inten,
                               logic [bmpd_pkg::SAMPLE_W-1:0] skip);
            intensity = inten;
            skip_count = skip;
        endfunction

        // q1.16 decay factor per fade step, dark from the final step on
        function logic [16:0] decay_factor(logic [bmpd_pkg::STEP_W-1:0] idx);
            if (int'(idx) >= NFADE - 1)
                return 17'd0;
            case (idx)
                5'd0:    return 17'd65536;
                5'd1:    return 17'd63170;
                5'd2:    return 17'd60693;
                5'd3:    return 17'd58091;
                5'd4:    return 17'd55365;
                5'd5:    return 17'd52521;
                5'd6:    return 17'd49558;
                5'd7:    return 17'd46472;
                5'd8:    return 17'd43267;
                5'd9:    return 17'd39938;
                5'd10:   return 17'd36484;
                5'd11:   return 17'd32919;
                5'd12:   return 17'd29223;
                5'd13:   return 17'd25415;
                5'd14:   return 17'd21476;
                5'd15:   return 17'd17426;
                5'd16:   return 17'd13251;
                5'd17:   return 17'd8952;
                default: return 17'd4535;
            endcase
        endfunction

        // apply one accepted item; returns 0 when the meter ignores it
        function bit note_item(logic op, logic [bmpd_pkg::COL_W-1:0] c,
                               logic [bmpd_pkg::SAMPLE_W-1:0] smp);
            column_report_t             batch [NCOL];
            logic [32:0]                prod;
            logic [31:0]                scaled;
            logic [bmpd_pkg::LIT_W-1:0] lit;
            int                         darks;
            if (op == bmpd_pkg::OP_LOAD)
            begin
                pend_val[c] = smp;
                pend_flag = 1'b1;
                running = 1'b1;
                return 1'b1;
            end
            if (!running)
                return 1'b0;
            if (prescale < skip_count)
            begin
                prescale = prescale + 16'd1;
                return 1'b1;
            end
            prescale = '0;
            darks = 0;
            for (int i = 0; i < NCOL; i++)
            begin
                // pending peak replaces a lower held level and restarts its fade
                if (pend_flag && pend_val[i] > held[i])
                begin
                    held[i] = pend_val[i];
                    fade_stage[i] = '0;
                end
                prod = held[i] * decay_factor(fade_stage[i]);
                held[i] = prod[31:16];
                if (int'(fade_stage[i]) < NFADE - 1)
                    fade_stage[i] = fade_stage[i] + 5'd1;
                else
                    darks++;
                lit = '0;
                for (int k = 0; k < NROW; k++)
                    if (32'(held[i]) > 32'(ROW_SPAN) * k)
                        lit = lit + 4'd1;
                scaled = held[i] * intensity;
                batch[i].col = i[bmpd_pkg::COL_W-1:0];
                batch[i].lvl = held[i];
                batch[i].lit = lit;
                batch[i].bright = scaled[31:16];
                batch[i].fin = (i == NCOL - 1);
                batch[i].dark = 1'b0;
            end
            pend_flag = 1'b0;
            // every column already dark: meter stops
            if (darks == NCOL)
                running = 1'b0;
            for (int i = 0; i < NCOL; i++)
            begin
                batch[i].dark = (darks == NCOL);
                awaited.push_back(batch[i]);
            end
            return 1'b1;
        endfunction

        function void check_column(logic [bmpd_pkg::COL_W-1:0] col,
                                   logic [bmpd_pkg::SAMPLE_W-1:0] lvl,
                                   logic [bmpd_pkg::LIT_W-1:0] lit,
                                   logic [bmpd_pkg::SAMPLE_W-1:0] bright,
                                   logic fin, logic dark);
            column_report_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected column item: col %0d level %h lit %0d bright %h",
                             col, lvl, lit, bright);
                return;
            end
            want = awaited.pop_front();
            if (col !== want.col || lvl !== want.lvl || lit !== want.lit ||
                bright !== want.bright || fin !== want.fin || dark !== want.dark)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("column item mismatch at %0t", $time);
                    $display("  want col %0d level %h lit %0d bright %h last %b dark %b",
                             want.col, want.lvl, want.lit, want.bright, want.fin, want.dark);
                    $display("  got  col %0d level %h lit %0d bright %h last %b dark %b",
                             col, lvl, lit, bright, fin, dark);
                end
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

// ===== sim/tb_bar_meter_peak_decay.sv =====
// tb_bar_meter_peak_decay: drives load and tick items into the bar meter with random gaps
// and back pressure, checks every column item against meter_book
// depends on bmpd_pkg, bmpd_tb_pkg and the bar_meter_peak_decay rtl
`timescale 1ns / 100ps

module tb_bar_meter_peak_decay;

    // longest quiet stretch of the back end after the last column item
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT = 14;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [bmpd_pkg::CFG_IDX_W-1:0] cfg_index = bmpd_pkg::REG_INTENSITY;
    logic [bmpd_pkg::SAMPLE_W-1:0]  cfg_data = '0;
    logic                           in_valid = 1'b0;
    wire                            in_ready;
    logic                           opcode = bmpd_pkg::OP_LOAD;
    logic [bmpd_pkg::COL_W-1:0]     column = '0;
    logic [bmpd_pkg::SAMPLE_W-1:0]  sample = '0;
    wire                            out_valid;
    logic                           out_ready = 1'b0;
    wire [bmpd_pkg::COL_W-1:0]      out_column;
    wire [bmpd_pkg::SAMPLE_W-1:0]   level;
    wire [bmpd_pkg::LIT_W-1:0]      lit_rows;
    wire [bmpd_pkg::SAMPLE_W-1:0]   brightness;
    wire                            last;
    wire                            all_dark;

    bmpd_tb_pkg::meter_book book;
    bit        steady = 1'b0;   // no idling on either side while set
    int        live_items = 0;  // accepted items the meter acted on

    bar_meter_peak_decay dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .column     (column),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_column (out_column),
        .level      (level),
        .lit_rows   (lit_rows),
        .brightness (brightness),
        .last       (last),
        .all_dark   (all_dark)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // column item checker with random back pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_column(out_column, level, lit_rows, brightness, last, all_dark);
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // sample values leaning toward the extremes
    function automatic logic [bmpd_pkg::SAMPLE_W-1:0] pick_sample();
        logic [bmpd_pkg::SAMPLE_W-1:0] v;
        v = 16'($urandom);
        case ($urandom_range(7))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = {8'h00, v[7:0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic op, input logic [bmpd_pkg::COL_W-1:0] col,
                             input logic [bmpd_pkg::SAMPLE_W-1:0] smp);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        column <= col;
        sample <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (book.note_item(op, col, smp))
            live_items++;
    endtask

    // sender holds off until every predicted column item has arrived
    task automatic hold_until_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    // registers change only with the meter idle
    task automatic apply_setting(input logic [bmpd_pkg::SAMPLE_W-1:0] inten,
                                 input logic [bmpd_pkg::SAMPLE_W-1:0] skip);
        hold_until_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= bmpd_pkg::REG_INTENSITY;
        cfg_data <= inten;
        @(posedge clk);
        cfg_index <= bmpd_pkg::REG_SKIP_COUNT;
        cfg_data <= skip;
        @(posedge clk);
        cfg_write <= 1'b0;
        book.set_regs(inten, skip);
    endtask

    // mostly load bursts followed by tick runs of up to 24 ticks, some long enough to fade out, some stray items
    task automatic random_traffic(input int n);
        int start;
        int loads;
        int ticks;
        start = live_items;
        while (live_items - start < n)
        begin
            if ($urandom_range(99) < 85)
            begin
                loads = $urandom_range(1, 3);
                repeat (loads)
                    send_item(bmpd_pkg::OP_LOAD, 4'($urandom_range(15)), pick_sample());
                ticks = $urandom_range(1, 24);
                repeat (ticks)
                    send_item(bmpd_pkg::OP_TICK, 4'($urandom_range(15)), 16'($urandom));
            end
            else
                send_item(1'($urandom_range(1)), 4'($urandom_range(15)), pick_sample());
        end
    endtask

    initial
    begin
        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        apply_setting(16'hFFFF, 16'h0000);

        // tick while stopped does nothing
        send_item(bmpd_pkg::OP_TICK, 4'd0, 16'h0000);
        // first peaks at the column and sample extremes
        send_item(bmpd_pkg::OP_LOAD, 4'd0, 16'hFFFF);
        send_item(bmpd_pkg::OP_LOAD, 4'd15, 16'h0001);
        send_item(bmpd_pkg::OP_LOAD, 4'd7, 16'h8000);
        send_item(bmpd_pkg::OP_LOAD, 4'd9, 16'h0000);
        send_item(bmpd_pkg::OP_TICK, 4'd15, 16'hFFFF);
        send_item(bmpd_pkg::OP_TICK, 4'd5, 16'h1234);
        // load below the held level is not taken
        send_item(bmpd_pkg::OP_LOAD, 4'd0, 16'h0100);
        send_item(bmpd_pkg::OP_TICK, 4'd0, 16'h0000);
        // later load to the same column overrides the earlier one
        send_item(bmpd_pkg::OP_LOAD, 4'd15, 16'hFFFF);
        send_item(bmpd_pkg::OP_LOAD, 4'd15, 16'h0000);
        send_item(bmpd_pkg::OP_TICK, 4'd0, 16'h0000);
        // stale pending samples come back with any new load
        send_item(bmpd_pkg::OP_LOAD, 4'd3, 16'h0000);
        send_item(bmpd_pkg::OP_TICK, 4'd0, 16'h0000);

        // prescaler skips two ticks between updates, zero intensity
        apply_setting(16'h0000, 16'h0002);
        repeat (5) send_item(bmpd_pkg::OP_TICK, 4'd0, 16'h0000);

        // random phases over several register settings
        apply_setting(16'hFFFF, 16'h0000);
        random_traffic(10);
        hold_until_done();
        random_traffic(10);

        steady = 1'b1;
        apply_setting(16'h8000, 16'h0000);
        random_traffic(20);
        steady = 1'b0;

        apply_setting(16'h0001, 16'h0001);
        random_traffic(20);

        // longest prescale: ticks only count
        apply_setting(16'($urandom), 16'hFFFF);
        random_traffic(10);

        apply_setting(16'($urandom), 16'h0000);
        random_traffic(20);

        hold_until_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
